// ----- rtl/tswt_pkg.sv -----
// Package for the timed square-wave tone block.
// Holds the item structs, field widths and timing constants; no dependencies.
`default_nettype none

package tswt_pkg;

  // Field and state widths
  localparam int HZ_W    = 15;
  localparam int MS_W    = 16;
  localparam int HALF_W  = 19;
  localparam int CYC_W   = 21;
  localparam int REST_W  = 26;

  // Shared divider geometry
  localparam int DVD_W     = 32;
  localparam int DVS_W     = 16;
  localparam int DIV_STEPS = DVD_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Timing constants
  localparam logic [DVD_W-1:0] US_PER_S   = DVD_W'(1000000);
  localparam logic [DVS_W-1:0] MS_PER_S   = DVS_W'(1000);
  localparam logic [CYC_W-1:0] CYCLES_MAX = {CYC_W{1'b1}};

  // Item modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [HZ_W-1:0] freq_hz;
    logic [MS_W-1:0] duration_ms;
  } in_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/tswt_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the note loader.
// Depends on tswt_pkg for operand widths and step count.
`default_nettype none

module tswt_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [tswt_pkg::DVD_W-1:0]    dividend,
  input  wire logic [tswt_pkg::DVS_W-1:0]    divisor,
  output logic                               done,
  output logic      [tswt_pkg::DVD_W-1:0]    quotient
);

  localparam logic [tswt_pkg::DCNT_W-1:0] LAST =
    tswt_pkg::DCNT_W'(tswt_pkg::DIV_STEPS - 1);

  logic                          busy;
  logic [tswt_pkg::DCNT_W-1:0]   cnt;
  logic [tswt_pkg::DVD_W-1:0]    work;
  logic [tswt_pkg::DVS_W-1:0]    rem;
  logic [tswt_pkg::DVS_W-1:0]    dvs;

  logic [tswt_pkg::DVS_W:0]      shifted;
  logic [tswt_pkg::DVS_W:0]      diff;
  logic                          fits;

  // One trial subtraction per cycle
  always_comb begin
    shifted = {rem, work[tswt_pkg::DVD_W-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  // Control: step counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      done <= (cnt == LAST);
      busy <= (cnt != LAST);
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: quotient bits shift into the freed low end of the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[tswt_pkg::DVD_W-2:0], fits};
      rem  <= fits ? diff[tswt_pkg::DVS_W-1:0] : shifted[tswt_pkg::DVS_W-1:0];
    end
  end

  assign quotient = work;

endmodule

`default_nettype wire

// ----- rtl/timed_square_wave_tone.sv -----
// Square-wave tone player. A tick item (one microsecond) gives its result on the
// next cycle, and so does a rest load. A tone load makes two 32-step passes
// through the shared restoring divider (cycle count = hz*ms/1000, then half
// period = 1000000/hz/2); input stalls meanwhile. Every item gives exactly one
// result through an output register, so a new item is taken only when that
// register is empty or its result leaves in the same cycle.
// Depends on tswt_pkg and tswt_div.
`default_nettype none

module timed_square_wave_tone (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire tswt_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tswt_pkg::out_t     out_data
);

  typedef enum logic [1:0] {S_IDLE, S_DIV_CYC, S_DIV_HP, S_FIN} state_t;

  state_t state;

  // Note state
  logic                          pin_level_reg;
  logic [tswt_pkg::HALF_W-1:0]   half_period;
  logic [tswt_pkg::HALF_W-1:0]   phase_count;
  logic [tswt_pkg::CYC_W-1:0]    cycles_left;
  logic [tswt_pkg::REST_W-1:0]   rest_count;
  logic                          tone_active;

  // Load scratch
  logic [tswt_pkg::HZ_W-1:0]     hz_reg;
  logic [tswt_pkg::CYC_W-1:0]    cyc_reg;
  logic [tswt_pkg::HALF_W-1:0]   hp_reg;

  // Divider hookup
  logic                          div_start;
  logic [tswt_pkg::DVD_W-1:0]    div_dividend;
  logic [tswt_pkg::DVS_W-1:0]    div_divisor;
  logic                          div_done;
  logic [tswt_pkg::DVD_W-1:0]    div_q;

  logic                          out_free;
  logic                          in_accept;
  logic                          is_tick;
  logic                          is_rest;
  logic                          is_tone;
  logic                          fin_apply;
  logic [tswt_pkg::DVD_W-1:0]    product;
  logic [tswt_pkg::REST_W+5:0]   rest_prod;

  // Tick next-state
  logic                          pin_level_next;
  logic [tswt_pkg::HALF_W-1:0]   half_period_next;
  logic [tswt_pkg::HALF_W-1:0]   phase_count_next;
  logic [tswt_pkg::CYC_W-1:0]    cycles_left_next;
  logic [tswt_pkg::REST_W-1:0]   rest_count_next;
  logic                          tone_active_next;
  logic [tswt_pkg::HALF_W-1:0]   phase_inc;
  logic [tswt_pkg::CYC_W-1:0]    cycles_dec;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;
  assign is_tick   = in_accept && (in_data.mode == tswt_pkg::MODE_TICK);
  assign is_rest   = in_accept && (in_data.mode == tswt_pkg::MODE_LOAD) &&
                     (in_data.freq_hz == '0);
  assign is_tone   = in_accept && (in_data.mode == tswt_pkg::MODE_LOAD) &&
                     (in_data.freq_hz != '0);
  assign fin_apply = (state == S_FIN) && out_free;

  assign product   = tswt_pkg::DVD_W'(in_data.freq_hz) *
                     tswt_pkg::DVD_W'(in_data.duration_ms);
  assign rest_prod = (tswt_pkg::REST_W+6)'(in_data.duration_ms) *
                     (tswt_pkg::REST_W+6)'(tswt_pkg::MS_PER_S);

  // Feed the divider: cycle count first, then period
  assign div_start    = is_tone || ((state == S_DIV_CYC) && div_done);
  assign div_dividend = (state == S_IDLE) ? product : tswt_pkg::US_PER_S;
  assign div_divisor  = (state == S_IDLE) ? tswt_pkg::MS_PER_S
                                          : tswt_pkg::DVS_W'(hz_reg);

  tswt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Advance the note by one tick
  always_comb begin
    pin_level_next   = pin_level_reg;
    half_period_next = half_period;
    phase_count_next = phase_count;
    cycles_left_next = cycles_left;
    rest_count_next  = rest_count;
    tone_active_next = tone_active;
    phase_inc        = phase_count + 1'b1;
    cycles_dec       = cycles_left - 1'b1;
    if (tone_active) begin
      phase_count_next = phase_inc;
      if (phase_inc >= half_period) begin
        phase_count_next = '0;
        if (pin_level_reg) begin
          pin_level_next = 1'b0;
        end else if (cycles_dec == '0) begin
          pin_level_next   = 1'b0;
          half_period_next = '0;
          cycles_left_next = '0;
          rest_count_next  = '0;
          tone_active_next = 1'b0;
        end else begin
          cycles_left_next = cycles_dec;
          pin_level_next   = 1'b1;
        end
      end
    end else if (rest_count != '0) begin
      rest_count_next = rest_count - 1'b1;
    end
  end

  // Sequencer, note state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      pin_level_reg <= 1'b0;
      half_period   <= '0;
      phase_count   <= '0;
      cycles_left   <= '0;
      rest_count    <= '0;
      tone_active   <= 1'b0;
    end else begin
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (is_tick) begin
            pin_level_reg      <= pin_level_next;
            half_period        <= half_period_next;
            phase_count        <= phase_count_next;
            cycles_left        <= cycles_left_next;
            rest_count         <= rest_count_next;
            tone_active        <= tone_active_next;
            out_valid          <= 1'b1;
            out_data.pin_level <= pin_level_next;
            out_data.busy_res  <= tone_active_next || (rest_count_next != '0);
          end else if (is_rest) begin
            pin_level_reg      <= 1'b0;
            half_period        <= '0;
            phase_count        <= '0;
            cycles_left        <= '0;
            rest_count         <= rest_prod[tswt_pkg::REST_W-1:0];
            tone_active        <= 1'b0;
            out_valid          <= 1'b1;
            out_data.pin_level <= 1'b0;
            out_data.busy_res  <= rest_prod[tswt_pkg::REST_W-1:0] != '0;
          end else if (is_tone) begin
            hz_reg <= in_data.freq_hz;
            state  <= S_DIV_CYC;
          end
        end
        S_DIV_CYC: begin
          if (div_done) begin
            cyc_reg <= (div_q[tswt_pkg::DVD_W-1:tswt_pkg::CYC_W] != '0) ?
                       tswt_pkg::CYCLES_MAX : div_q[tswt_pkg::CYC_W-1:0];
            state   <= S_DIV_HP;
          end
        end
        S_DIV_HP: begin
          if (div_done) begin
            hp_reg <= div_q[tswt_pkg::HALF_W:1];
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_apply) begin
            phase_count <= '0;
            rest_count  <= '0;
            out_valid   <= 1'b1;
            if ((cyc_reg == '0) || (hp_reg == '0)) begin
              pin_level_reg      <= 1'b0;
              half_period        <= '0;
              cycles_left        <= '0;
              tone_active        <= 1'b0;
              out_data.pin_level <= 1'b0;
              out_data.busy_res  <= 1'b0;
            end else begin
              pin_level_reg      <= 1'b1;
              half_period        <= hp_reg;
              cycles_left        <= cyc_reg;
              tone_active        <= 1'b1;
              out_data.pin_level <= 1'b1;
              out_data.busy_res  <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tswt_check.sv -----
// Port-level checker for the tone block, bound to the top level.
// Depends on tswt_pkg and timed_square_wave_tone.
`default_nettype none

module tswt_check (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire tswt_pkg::in_t in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire tswt_pkg::out_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A tick item gives its result on the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.mode == tswt_pkg::MODE_TICK) |=> out_valid)
    else $error("tick item gave no result");

  // A tone load occupies the divider, so input stalls next
  a_tone_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.mode == tswt_pkg::MODE_LOAD) &&
    (in_data.freq_hz != '0) |=> in_stall)
    else $error("tone load did not stall input");

  // A rest load shows a low pin, busy unless its length is zero
  a_rest_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.mode == tswt_pkg::MODE_LOAD) &&
    (in_data.freq_hz == '0) |=> out_valid && !out_data.pin_level &&
    (out_data.busy_res == ($past(in_data.duration_ms) != '0)))
    else $error("rest load result wrong");

  // A high pin only shows while a note plays
  a_pin_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pin_level |-> out_data.busy_res)
    else $error("pin high while idle");

endmodule

bind timed_square_wave_tone tswt_check u_tswt_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- bench/timed_square_wave_tone_tb.sv -----
`timescale 1ns / 100ps
// Testbench for timed_square_wave_tone: directed note table, then random note runs.
// Checks pin level and busy flag against the typed table rows or an in-bench tone predictor; needs tswt_pkg.

module timed_square_wave_tone_tb;

  localparam int SHORT_DRAIN  = 100;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 380;
  localparam int HOLD_SEQ     = 1;
  localparam int DRAIN_SEQ    = 2;
  localparam int PLAYED_SEQ   = 3;

  logic           clk = 1'b0;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  tswt_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall = 1'b0;
  tswt_pkg::out_t out_data;

  timed_square_wave_tone u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Directed table: typed rows carry a result that is obvious from the note rules
  typedef struct packed {
    logic           typed;
    tswt_pkg::in_t  item;
    tswt_pkg::out_t want;
  } note_row_t;

  localparam int NOTE_ROWS_N = 23;
  localparam note_row_t NOTE_ROWS [NOTE_ROWS_N] = '{
    // tick while idle, all field bits high, then all low
    '{1'b1, '{tswt_pkg::MODE_TICK, 15'h7FFF, 16'hFFFF}, '{1'b0, 1'b0}},
    '{1'b1, '{tswt_pkg::MODE_TICK, 15'h0000, 16'h0000}, '{1'b0, 1'b0}},
    // zero rest, zero cycles, cycle count rounding down to zero
    '{1'b1, '{tswt_pkg::MODE_LOAD, 15'd0,    16'd0},    '{1'b0, 1'b0}},
    '{1'b1, '{tswt_pkg::MODE_LOAD, 15'd1000, 16'd0},    '{1'b0, 1'b0}},
    '{1'b1, '{tswt_pkg::MODE_LOAD, 15'd999,  16'd1},    '{1'b0, 1'b0}},
    // short rest, one tick into it
    '{1'b1, '{tswt_pkg::MODE_LOAD, 15'd0,    16'd1},    '{1'b0, 1'b1}},
    '{1'b1, '{tswt_pkg::MODE_TICK, 15'h1234, 16'h4321}, '{1'b0, 1'b1}},
    // highest pitch, longest note: cycle count saturates, pin goes high at once
    '{1'b1, '{tswt_pkg::MODE_LOAD, 15'h7FFF, 16'hFFFF}, '{1'b1, 1'b1}},
    '{1'b0, '{tswt_pkg::MODE_TICK, 15'd0,    16'd0},    '{1'b0, 1'b0}},
    '{1'b0, '{tswt_pkg::MODE_TICK, 15'd0,    16'd0},    '{1'b0, 1'b0}},
    '{1'b0, '{tswt_pkg::MODE_TICK, 15'd0,    16'd0},    '{1'b0, 1'b0}},
    '{1'b0, '{tswt_pkg::MODE_TICK, 15'd0,    16'd0},    '{1'b0, 1'b0}},
    '{1'b0, '{tswt_pkg::MODE_TICK, 15'd0,    16'd0},    '{1'b0, 1'b0}},
    // lowest pitch replaces the playing tone
    '{1'b1, '{tswt_pkg::MODE_LOAD, 15'd1,    16'hFFFF}, '{1'b1, 1'b1}},
    '{1'b0, '{tswt_pkg::MODE_TICK, 15'h7FFF, 16'hFFFF}, '{1'b0, 1'b0}},
    // longest rest replaces the tone
    '{1'b1, '{tswt_pkg::MODE_LOAD, 15'd0,    16'hFFFF}, '{1'b0, 1'b1}},
    '{1'b0, '{tswt_pkg::MODE_TICK, 15'd0,    16'd0},    '{1'b0, 1'b0}},
    '{1'b1, '{tswt_pkg::MODE_LOAD, 15'd20000, 16'd1},   '{1'b1, 1'b1}},
    '{1'b1, '{tswt_pkg::MODE_LOAD, 15'h5555, 16'hAAAA}, '{1'b1, 1'b1}},
    '{1'b1, '{tswt_pkg::MODE_LOAD, 15'h2AAA, 16'h5555}, '{1'b1, 1'b1}},
    '{1'b1, '{tswt_pkg::MODE_LOAD, 15'd1000, 16'd1},    '{1'b1, 1'b1}},
    '{1'b0, '{tswt_pkg::MODE_TICK, 15'd0,    16'd0},    '{1'b0, 1'b0}},
    '{1'b0, '{tswt_pkg::MODE_TICK, 15'd0,    16'd0},    '{1'b0, 1'b0}}
  };

  // Tone predictor state
  logic                        tone_pin;
  logic [tswt_pkg::HALF_W-1:0] tone_half;
  logic [tswt_pkg::HALF_W-1:0] tone_phase;
  logic [tswt_pkg::CYC_W-1:0]  tone_cycles;
  logic [tswt_pkg::REST_W-1:0] rest_left;
  logic                        tone_on;

  tswt_pkg::out_t level_due_q[$];
  int   fail_count   = 0;
  int   results_seen = 0;
  int   items_sent   = 0;
  int   loads_sent   = 0;
  int   notes_done   = 0;
  int   burst_left   = 0;
  bit   no_gaps      = 1'b0;
  bit   valid_on     = 1'b0;
  logic hold_ask     = 1'b0;

  function automatic void note_clear();
    tone_pin    = 1'b0;
    tone_half   = '0;
    tone_phase  = '0;
    tone_cycles = '0;
    rest_left   = '0;
    tone_on     = 1'b0;
  endfunction

  function automatic logic note_busy();
    return tone_on || (rest_left != '0);
  endfunction

  // Advance the note state by one item and return the pin and busy flag after it
  task automatic play_item(input tswt_pkg::in_t it, output tswt_pkg::out_t res);
    logic [63:0] cyc;
    logic [31:0] hp;
    logic        was_busy;
    was_busy = note_busy();
    if (it.mode == tswt_pkg::MODE_LOAD) begin
      note_clear();
      loads_sent++;
      if (it.freq_hz == '0) begin
        rest_left = tswt_pkg::REST_W'(32'(it.duration_ms) * 32'(tswt_pkg::MS_PER_S));
      end else begin
        cyc = 64'(it.freq_hz) * 64'(it.duration_ms) / 64'(tswt_pkg::MS_PER_S);
        hp  = (32'(tswt_pkg::US_PER_S) / 32'(it.freq_hz)) / 32'd2;
        if (cyc > 64'(tswt_pkg::CYCLES_MAX)) cyc = 64'(tswt_pkg::CYCLES_MAX);
        if (cyc != '0 && hp[tswt_pkg::HALF_W-1:0] != '0) begin
          tone_cycles = cyc[tswt_pkg::CYC_W-1:0];
          tone_half   = hp[tswt_pkg::HALF_W-1:0];
          tone_on     = 1'b1;
          tone_pin    = 1'b1;
        end
      end
    end else if (tone_on) begin
      tone_phase = tone_phase + 1'b1;
      if (tone_phase >= tone_half) begin
        tone_phase = '0;
        if (tone_pin) begin
          tone_pin = 1'b0;
        end else begin
          tone_cycles = tone_cycles - 1'b1;
          if (tone_cycles == '0) note_clear();
          else tone_pin = 1'b1;
        end
      end
    end else if (rest_left != '0) begin
      rest_left = rest_left - 1'b1;
    end
    res.pin_level = tone_pin;
    res.busy_res  = note_busy();
    if (was_busy && !res.busy_res && it.mode == tswt_pkg::MODE_TICK) notes_done++;
  endtask

  // Idle between bursts unless gaps are switched off
  task automatic pace();
    int gap;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 6);
    in_valid <= 1'b0;
    valid_on = 1'b0;
    repeat (gap) @(posedge clk);
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                             : $urandom_range(1, 12);
  endtask

  // Offer one item, hold it until taken, then queue its expected result
  task automatic offer_item(input tswt_pkg::in_t it, input logic typed,
                            input tswt_pkg::out_t want);
    tswt_pkg::out_t pred;
    in_valid <= 1'b1;
    in_data  <= it;
    valid_on = 1'b1;
    do @(posedge clk); while (in_stall);
    play_item(it, pred);
    level_due_q.push_back(typed ? want : pred);
    items_sent++;
    pace();
  endtask

  function automatic tswt_pkg::in_t make_item(logic mode, int hz, int ms);
    tswt_pkg::in_t it;
    it.mode        = mode;
    it.freq_hz     = tswt_pkg::HZ_W'(hz);
    it.duration_ms = tswt_pkg::MS_W'(ms);
    return it;
  endfunction

  task automatic offer_checked(input tswt_pkg::in_t it);
    offer_item(it, 1'b0, '0);
  endtask

  task automatic offer_tick();
    offer_checked(make_item(tswt_pkg::MODE_TICK, $urandom_range(0, 32767),
                            $urandom_range(0, 65535)));
  endtask

  // Drop valid and wait until every queued result is back
  task automatic drain_results();
    if (valid_on) begin
      in_valid <= 1'b0;
      valid_on = 1'b0;
    end
    while (level_due_q.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_pitch();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return $urandom_range(1, 32767);
      2:       return $urandom_range(20000, 32767);
      default: return $urandom_range(1, 20000);
    endcase
  endfunction

  function automatic int pick_length();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Stimulus
  initial begin
    int seq;
    int n;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    note_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < NOTE_ROWS_N; i++)
      offer_item(NOTE_ROWS[i].item, NOTE_ROWS[i].typed, NOTE_ROWS[i].want);
    drain_results();

    // random note runs: mostly load followed by ticks, one played to the end
    seq = 0;
    while (items_sent < NOTE_ROWS_N + RANDOM_ITEMS || seq <= PLAYED_SEQ) begin
      if (seq == HOLD_SEQ) begin
        // receiver holds off while items keep coming back to back
        hold_ask <= 1'b1;
        no_gaps = 1'b1;
        repeat (40) offer_tick();
        no_gaps = 1'b0;
      end
      if (seq == DRAIN_SEQ) drain_results();
      if ($urandom_range(0, 7) == 0)
        offer_checked(make_item(1'($urandom_range(0, 1)), $urandom_range(0, 32767),
                                $urandom_range(0, 65535)));
      if (seq == PLAYED_SEQ) begin
        // shortest tone that ends: one cycle of two halves of about 250 ticks
        offer_checked(make_item(tswt_pkg::MODE_LOAD, $urandom_range(1990, 1999), 1));
        while (note_busy()) offer_tick();
        repeat ($urandom_range(1, 4)) offer_tick();
      end else begin
        offer_checked(make_item(tswt_pkg::MODE_LOAD, pick_pitch(), pick_length()));
        n = $urandom_range(0, 40);
        repeat (n) offer_tick();
      end
      seq++;
    end

    drain_results();
    repeat (SHORT_DRAIN) @(posedge clk);
    $display("Ran %0d items (%0d loads) and checked %0d results; %0d notes played to the end.",
             items_sent, loads_sent, results_seen, notes_done);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Receiver stall: random styles, plus one long hold on request
  int       hold_left  = 0;
  bit       hold_taken = 1'b0;
  int       style      = 0;
  int       style_left = 0;
  bit [7:0] stall_bits = 8'b1011_0010;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ask && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else begin
      if (style_left == 0) begin
        style      <= $urandom_range(0, 2);
        style_left <= $urandom_range(20, 120);
      end else begin
        style_left <= style_left - 1;
      end
      case (style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          out_stall  <= stall_bits[0];
          stall_bits <= {stall_bits[0], stall_bits[7:1]};
        end
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    tswt_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (level_due_q.size() == 0) begin
        $error("result with nothing expected: pin_level %0d busy_res %0d",
               out_data.pin_level, out_data.busy_res);
        fail_count++;
      end else begin
        want = level_due_q.pop_front();
        if (out_data.pin_level !== want.pin_level) begin
          $error("pin_level: expected %0d, got %0d", want.pin_level, out_data.pin_level);
          fail_count++;
        end
        if (out_data.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_data.busy_res);
          fail_count++;
        end
      end
    end
  end

  // Give up after a generous fixed time
  initial begin
    #1000000;
    $display("Timed out with %0d results still expected.", level_due_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- timed_square_wave_tone.f -----
rtl/tswt_pkg.sv
rtl/tswt_div.sv
rtl/timed_square_wave_tone.sv
rtl/tswt_check.sv
bench/timed_square_wave_tone_tb.sv
